[hw/rtl/abff_pkg.sv]
package abff_pkg;

    localparam int NUM_WORDS_DEF = 16;
    localparam int WORD_BITS_DEF = 64;

    localparam int ACT_W  = 3;
    localparam int IDX_W  = 10;
    localparam int WIU_W  = 5;

    localparam logic [WIU_W-1:0] WIU_RESET = 5'd16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TEST       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND_CLEAR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIND_SET   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SET_ALL    = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] bit_index;
    } in_item_t;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             all_clear;
        logic             all_set;
    } out_item_t;

    // per-word status from the shared word unit
    typedef struct packed {
        logic has_one;
        logic is_zero;
        logic is_ones;
    } word_stat_t;

endpackage

[hw/rtl/abff_ram.sv]
module abff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/abff_word_unit.sv]
module abff_word_unit #(
    parameter int WORD_BITS = abff_pkg::WORD_BITS_DEF,
    localparam int POS_W = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic                 invert,
    output abff_pkg::word_stat_t stat,
    output logic [POS_W-1:0]     pos
);

    logic [WORD_BITS-1:0] srch;
    logic [WORD_BITS-1:0] lowest;

    // isolate the lowest one with a two's complement, then encode it
    assign srch   = invert ? ~word : word;
    assign lowest = srch & (~srch + {{(WORD_BITS-1){1'b0}}, 1'b1});

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (lowest[b])
            begin
                pos = pos | POS_W'(b);
            end
        end
    end

    assign stat.has_one = |srch;
    assign stat.is_zero = ~|word;
    assign stat.is_ones = &word;

endmodule

[hw/rtl/allocation_bitmap_find_first_unit.sv]
// Allocation bitmap with find-first-clear / find-first-set, one item at a time.
// Each item runs through states in order: a find or unused code goes straight to the scan,
// set/clear/test splits the index, reads and modifies the word (skipped outside the store),
// then scans; clear/set all fills every word first. The scan reads one word a cycle.
// The next input is taken only once the result has gone to the output register.
// Reset: asynchronous; a clearing pass then zeroes every word of the store.
module allocation_bitmap_find_first_unit #(
    parameter int NUM_WORDS = abff_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = abff_pkg::WORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  abff_pkg::in_item_t         in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output abff_pkg::out_item_t        out_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [abff_pkg::WIU_W-1:0] cfg_data
);

    localparam int IDX_W  = abff_pkg::IDX_W;
    localparam int ACT_W  = abff_pkg::ACT_W;
    localparam int WIU_W  = abff_pkg::WIU_W;
    localparam int POS_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W  = $clog2(NUM_WORDS + 1);
    localparam int CMP_W  = (CNT_W > WIU_W) ? CNT_W : WIU_W;
    // floor reciprocal: the quotient estimate is low by at most one
    localparam int RSH    = 16;
    localparam int PROD_W = IDX_W + RSH + 1;
    localparam logic [RSH:0] RECIP = (RSH + 1)'((1 << RSH) / WORD_BITS);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_SPLIT  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_MODIFY = 9'b000100000,
        S_FILL   = 9'b001000000,
        S_SCAN   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [ACT_W-1:0]  act_reg,   act_next;
    logic [IDX_W-1:0]  bidx_reg,  bidx_next;
    logic [IDX_W-1:0]  q_reg,     q_next;
    logic [IDX_W-1:0]  word_reg,  word_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [CMP_W-1:0]  cnt_reg,   cnt_next;
    logic              rdv_reg,   rdv_next;
    logic [IDX_W-1:0]  base_reg,  base_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  fidx_reg,  fidx_next;
    logic              aclr_reg,  aclr_next;
    logic              aset_reg,  aset_next;
    logic              bval_reg,  bval_next;
    logic              fval_reg,  fval_next;
    logic [WIU_W-1:0]  wiu_reg;
    logic              ovld_reg,  ovld_next;
    abff_pkg::out_item_t oitem_reg, oitem_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    abff_pkg::word_stat_t wstat;
    logic [POS_W-1:0]     wpos;
    logic                 is_find;

    logic [CMP_W-1:0]     n_words;
    logic [PROD_W-1:0]    recip_prod;
    logic [IDX_W-1:0]     split_prod;
    logic [IDX_W-1:0]     split_rem;
    logic [WORD_BITS-1:0] bit_mask;

    abff_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared word unit: inspects whichever word the RAM returned this cycle
    abff_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .word   (ram_rdata),
        .invert (act_reg == abff_pkg::ACT_FIND_CLEAR),
        .stat   (wstat),
        .pos    (wpos)
    );

    assign is_find = (act_reg == abff_pkg::ACT_FIND_CLEAR) ||
                     (act_reg == abff_pkg::ACT_FIND_SET);

    // words covered by searches and checks; a count above the store clamps
    always_comb
    begin
        if (CMP_W'(wiu_reg) > CMP_W'(NUM_WORDS))
        begin
            n_words = CMP_W'(NUM_WORDS);
        end
        else
        begin
            n_words = CMP_W'(wiu_reg);
        end
    end

    // bit index split into word and position, two registered steps
    assign recip_prod = PROD_W'(bidx_reg) * PROD_W'(RECIP);
    assign split_prod = IDX_W'(q_reg * WORD_BITS);
    assign split_rem  = bidx_reg - split_prod;
    assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ovld_reg;
    assign out_item  = oitem_reg;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        bidx_next  = bidx_reg;
        q_next     = q_reg;
        word_next  = word_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        rdv_next   = 1'b0;
        base_next  = base_reg;
        found_next = found_reg;
        fidx_next  = fidx_reg;
        aclr_next  = aclr_reg;
        aset_next  = aset_reg;
        bval_next  = bval_reg;
        fval_next  = fval_reg;
        ovld_next  = ovld_reg && !out_ready;
        oitem_next = oitem_reg;

        ram_we    = 1'b0;
        ram_waddr = cnt_reg[ADDR_W-1:0];
        ram_wdata = {WORD_BITS{fval_reg}};
        ram_re    = 1'b0;
        ram_raddr = cnt_reg[ADDR_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                // zero the store one word a cycle
                ram_we    = 1'b1;
                ram_wdata = '0;
                cnt_next  = cnt_reg + CMP_W'(1);
                if (cnt_reg == CMP_W'(NUM_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cnt_next   = '0;
                base_next  = '0;
                found_next = 1'b0;
                fidx_next  = '0;
                aclr_next  = 1'b1;
                aset_next  = 1'b1;
                bval_next  = 1'b0;
                if (in_valid)
                begin
                    act_next  = in_item.action;
                    bidx_next = in_item.bit_index;
                    case (in_item.action)
                        abff_pkg::ACT_SET,
                        abff_pkg::ACT_CLEAR,
                        abff_pkg::ACT_TEST:
                        begin
                            state_next = S_DIV;
                        end
                        abff_pkg::ACT_CLEAR_ALL:
                        begin
                            fval_next  = 1'b0;
                            state_next = S_FILL;
                        end
                        abff_pkg::ACT_SET_ALL:
                        begin
                            fval_next  = 1'b1;
                            state_next = S_FILL;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                q_next     = recip_prod[RSH +: IDX_W];
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                // correct the low estimate with one compare and subtract
                if (split_rem >= IDX_W'(WORD_BITS))
                begin
                    word_next = q_reg + IDX_W'(1);
                    pos_next  = POS_W'(split_rem - IDX_W'(WORD_BITS));
                end
                else
                begin
                    word_next = q_reg;
                    pos_next  = POS_W'(split_rem);
                end
                // outside the store: drop the access, report status only
                if (32'(word_next) < 32'(NUM_WORDS))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = word_reg[ADDR_W-1:0];
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                ram_waddr = word_reg[ADDR_W-1:0];
                case (act_reg)
                    abff_pkg::ACT_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | bit_mask;
                    end
                    abff_pkg::ACT_CLEAR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~bit_mask;
                    end
                    default:
                    begin
                        bval_next = ram_rdata[pos_reg];
                    end
                endcase
                state_next = S_SCAN;
            end

            S_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CMP_W'(1);
                if (cnt_reg == CMP_W'(NUM_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle; inspect the word from the cycle before
                if (cnt_reg < n_words)
                begin
                    ram_re   = 1'b1;
                    rdv_next = 1'b1;
                    cnt_next = cnt_reg + CMP_W'(1);
                end
                if (rdv_reg)
                begin
                    if (!wstat.is_zero)
                    begin
                        aclr_next = 1'b0;
                    end
                    if (!wstat.is_ones)
                    begin
                        aset_next = 1'b0;
                    end
                    if (is_find && !found_reg && wstat.has_one)
                    begin
                        found_next = 1'b1;
                        fidx_next  = base_reg + IDX_W'(wpos);
                    end
                    base_next = base_reg + IDX_W'(WORD_BITS);
                end
                if (!(cnt_reg < n_words) && !rdv_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!ovld_reg || out_ready)
                begin
                    ovld_next              = 1'b1;
                    oitem_next.bit_value   = bval_reg;
                    oitem_next.found       = found_reg;
                    oitem_next.found_index = fidx_reg;
                    oitem_next.all_clear   = aclr_reg;
                    oitem_next.all_set     = aset_reg;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
            wiu_reg   <= abff_pkg::WIU_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
            ovld_reg  <= ovld_next;
            if (cfg_valid)
            begin
                wiu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        bidx_reg  <= bidx_next;
        q_reg     <= q_next;
        word_reg  <= word_next;
        pos_reg   <= pos_next;
        base_reg  <= base_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        aclr_reg  <= aclr_next;
        aset_reg  <= aset_next;
        bval_reg  <= bval_next;
        fval_reg  <= fval_next;
        oitem_reg <= oitem_next;
    end

endmodule

[tb/sv/bitmap_result_checker.sv]
module bitmap_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  abff_pkg::in_item_t         in_item,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  abff_pkg::out_item_t        out_item,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [abff_pkg::WIU_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output int                         checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WORDS = abff_pkg::NUM_WORDS_DEF;
    localparam int WORD_BITS = abff_pkg::WORD_BITS_DEF;
    localparam int IDX_W     = abff_pkg::IDX_W;

    bit [WORD_BITS-1:0]        bitmap [NUM_WORDS];
    bit [abff_pkg::WIU_W-1:0]  word_count = abff_pkg::WIU_RESET;
    abff_pkg::out_item_t       pending_status [$];
    int                        fail_cnt;
    int                        check_cnt;

    // Apply one request to the shadow bitmap and work out its status.
    function automatic abff_pkg::out_item_t apply_request(abff_pkg::in_item_t req);
        abff_pkg::out_item_t res;
        int               word_sel;
        int               bit_sel;
        int               span;
        int               hit_at;
        bit               hit;
        bit [WORD_BITS-1:0] w;
        res     = '0;
        hit     = 1'b0;
        hit_at  = 0;
        word_sel = int'(req.bit_index) / WORD_BITS;
        bit_sel  = int'(req.bit_index) % WORD_BITS;
        span     = (int'(word_count) > NUM_WORDS) ? NUM_WORDS : int'(word_count);
        case (req.action)
            abff_pkg::ACT_SET:
                if (word_sel < NUM_WORDS)
                    bitmap[word_sel][bit_sel] = 1'b1;
            abff_pkg::ACT_CLEAR:
                if (word_sel < NUM_WORDS)
                    bitmap[word_sel][bit_sel] = 1'b0;
            abff_pkg::ACT_TEST:
                if (word_sel < NUM_WORDS)
                    res.bit_value = bitmap[word_sel][bit_sel];
            abff_pkg::ACT_FIND_CLEAR, abff_pkg::ACT_FIND_SET:
            begin
                for (int i = 0; i < span && !hit; i++)
                begin
                    w = (req.action == abff_pkg::ACT_FIND_SET) ? bitmap[i] : ~bitmap[i];
                    for (int b = 0; b < WORD_BITS && !hit; b++)
                    begin
                        if (w[b])
                        begin
                            hit    = 1'b1;
                            hit_at = i * WORD_BITS + b;
                        end
                    end
                end
                res.found       = hit;
                res.found_index = hit_at[IDX_W-1:0];
            end
            abff_pkg::ACT_CLEAR_ALL:
                for (int i = 0; i < NUM_WORDS; i++)
                    bitmap[i] = '0;
            abff_pkg::ACT_SET_ALL:
                for (int i = 0; i < NUM_WORDS; i++)
                    bitmap[i] = '1;
            default:
                ;
        endcase
        res.all_clear = 1'b1;
        res.all_set   = 1'b1;
        for (int i = 0; i < span; i++)
        begin
            if (bitmap[i] != '0)
                res.all_clear = 1'b0;
            if (bitmap[i] != '1)
                res.all_set = 1'b0;
        end
        return res;
    endfunction

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        abff_pkg::out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                bitmap[i] = '0;
            word_count = abff_pkg::WIU_RESET;
            pending_status.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                word_count = cfg_data;
            if (in_valid && in_ready)
                pending_status.push_back(apply_request(in_item));
            if (out_valid && out_ready)
            begin
                if (pending_status.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, out_item);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_cnt++;
                    if (out_item.bit_value !== want.bit_value)
                        flag_field("bit_value", 32'(want.bit_value),
                                   32'(out_item.bit_value));
                    if (out_item.found !== want.found)
                        flag_field("found", 32'(want.found), 32'(out_item.found));
                    if (out_item.found_index !== want.found_index)
                        flag_field("found_index", 32'(want.found_index),
                                   32'(out_item.found_index));
                    if (out_item.all_clear !== want.all_clear)
                        flag_field("all_clear", 32'(want.all_clear),
                                   32'(out_item.all_clear));
                    if (out_item.all_set !== want.all_set)
                        flag_field("all_set", 32'(want.all_set), 32'(out_item.all_set));
                end
            end
            outstanding <= pending_status.size();
        end
        mismatches <= fail_cnt;
        checked    <= check_cnt;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACT_W = abff_pkg::ACT_W;
    localparam int IDX_W = abff_pkg::IDX_W;
    localparam int WIU_W = abff_pkg::WIU_W;

    // Code the block leaves undefined: no change, status bits only.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid = 1'b0;
    abff_pkg::in_item_t  in_item  = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    abff_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic [WIU_W-1:0]    cfg_data  = '0;
    logic                cfg_ready;

    int                  mismatches;
    int                  outstanding;
    int                  checked;
    int                  requests_sent;
    int                  count_writes;
    int                  ready_hold;
    bit                  no_idle;
    logic [WIU_W-1:0]    cur_count = abff_pkg::WIU_RESET;

    allocation_bitmap_find_first_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bitmap_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: alternate runs of ready with stalls of random length.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else if (no_idle || $urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold = idle_length();
        end
    end

    // Present one request and hold it until the transfer. Valid is left high
    // afterwards so that a back-to-back request never drops and raises it in
    // the same step; a gap lowers it first.
    task automatic send_request(input abff_pkg::in_item_t req);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic send(input logic [ACT_W-1:0] act, input int unsigned idx);
        abff_pkg::in_item_t req;
        req.action    = act;
        req.bit_index = idx[IDX_W-1:0];
        send_request(req);
    endtask

    // Drop valid and hold off until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Write the word count only once the block has gone quiet.
    task automatic write_word_count(input logic [WIU_W-1:0] count);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_count = count;
        count_writes++;
    endtask

    // Random request; most indices land inside the words in use so that
    // finds and the all-checks see the bits being changed.
    function automatic abff_pkg::in_item_t random_request(int set_bias);
        abff_pkg::in_item_t req;
        int                 r;
        int                 span;
        span = (cur_count == 0) ? 1 :
               ((cur_count > abff_pkg::NUM_WORDS_DEF) ? abff_pkg::NUM_WORDS_DEF
                                                      : int'(cur_count));
        r = $urandom_range(0, 99);
        if (r < 2)
            req.action = ACT_UNUSED;
        else if (r < 5)
            req.action = abff_pkg::ACT_CLEAR_ALL;
        else if (r < 8)
            req.action = abff_pkg::ACT_SET_ALL;
        else if (r < 22)
            req.action = abff_pkg::ACT_FIND_CLEAR;
        else if (r < 36)
            req.action = abff_pkg::ACT_FIND_SET;
        else if (r < 50)
            req.action = abff_pkg::ACT_TEST;
        else if ($urandom_range(0, 99) < set_bias)
            req.action = abff_pkg::ACT_SET;
        else
            req.action = abff_pkg::ACT_CLEAR;
        if ($urandom_range(0, 3) != 0)
            req.bit_index = IDX_W'($urandom_range(0, span * abff_pkg::WORD_BITS_DEF - 1));
        else
            req.bit_index = IDX_W'($urandom_range(0, 1023));
        return req;
    endfunction

    initial
    begin
        logic [WIU_W-1:0] count_plan [9];
        logic [WIU_W-1:0] next_count;
        int               set_bias;
        count_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2, 5'd17, 5'd0};

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, then the corner indices of the map.
        send(abff_pkg::ACT_TEST, 0);
        send(abff_pkg::ACT_FIND_CLEAR, 0);
        send(abff_pkg::ACT_FIND_SET, 0);
        send(abff_pkg::ACT_SET, 0);
        send(abff_pkg::ACT_SET, 1023);
        send(abff_pkg::ACT_SET, 63);
        send(abff_pkg::ACT_SET, 64);
        send(abff_pkg::ACT_TEST, 1023);
        send(abff_pkg::ACT_FIND_SET, 0);
        send(abff_pkg::ACT_CLEAR, 0);
        send(abff_pkg::ACT_FIND_SET, 0);
        // Clear on a bit that is already clear must leave it clear.
        send(abff_pkg::ACT_CLEAR, 200);
        send(abff_pkg::ACT_TEST, 200);
        send(ACT_UNUSED, 1023);
        send(abff_pkg::ACT_SET_ALL, 0);
        send(abff_pkg::ACT_FIND_CLEAR, 0);
        send(abff_pkg::ACT_CLEAR, 1023);
        send(abff_pkg::ACT_FIND_CLEAR, 0);
        send(abff_pkg::ACT_CLEAR_ALL, 1023);

        // One word in use: bits beyond it still change but are not searched.
        write_word_count(5'd1);
        send(abff_pkg::ACT_SET, 100);
        send(abff_pkg::ACT_TEST, 100);
        send(abff_pkg::ACT_FIND_SET, 0);
        send(abff_pkg::ACT_SET_ALL, 0);

        // No words in use: nothing found, both status bits high.
        write_word_count(5'd0);
        send(abff_pkg::ACT_FIND_CLEAR, 0);

        // Random phases, each with its own word count and set/clear balance.
        for (int p = 0; p < 9; p++)
        begin
            next_count = (p == 8) ? 5'($urandom_range(0, 31)) : count_plan[p];
            write_word_count(next_count);
            no_idle = (p % 4 == 2);
            case (p % 3)
                0:       set_bias = 85;
                1:       set_bias = 15;
                default: set_bias = $urandom_range(0, 100);
            endcase
            repeat (90) send_request(random_request(set_bias));
        end

        drain_results();
        repeat (48) @(posedge clk);

        $display("Run covered %0d requests and %0d checked results over %0d word-count",
                 requests_sent, checked, count_writes);
        $display("settings, including zero, one, the full store and counts above it.");
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/abff_pkg.sv
hw/rtl/abff_ram.sv
hw/rtl/abff_word_unit.sv
hw/rtl/allocation_bitmap_find_first_unit.sv
tb/sv/bitmap_result_checker.sv
tb/sv/tb.sv
